/* rtl/lhff_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lhff_pkg: shared types and constants of the lexicon hash frequency filter
// Holds the mode codes, the lookup transaction type carried down the cell
// chain and the sdbm hash step.
// ----------------------------------------------------------------------------
package lhff_pkg;

	localparam int unsigned HASH_W  = 64;
	localparam int unsigned FREQ_W  = 31;
	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned RATIO_W = 8;
	localparam int unsigned PROD_W  = FREQ_W + RATIO_W;

	localparam logic [RATIO_W-1:0] RATIO_RESET = 8'd5;
	localparam logic [FREQ_W-1:0]  FREQ_CLOSE  = 31'd1;

	// sdbm shift amounts
	localparam int unsigned SH_LO = 6;
	localparam int unsigned SH_HI = 16;

	typedef enum logic [1:0] {
		MODE_LEX     = 2'd0,
		MODE_CORRECT = 2'd1,
		MODE_ERROR   = 2'd2,
		MODE_NONE    = 2'd3
	} mode_t;

	// lookup transaction travelling along the chain of table cells
	typedef struct packed {
		logic              valid;
		logic [HASH_W-1:0] chash;
		logic [HASH_W-1:0] ehash;
		logic [FREQ_W-1:0] cfreq;
		logic [FREQ_W-1:0] efreq;
	} tok_t;

	// one sdbm step; a zero byte leaves the hash unchanged
	function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] h,
			input logic [CHAR_W-1:0] c);
		logic [HASH_W-1:0] cext;
		begin
			cext = {{(HASH_W-CHAR_W){c[CHAR_W-1]}}, c};
			if (c == '0) begin
				hash_step = h;
			end else begin
				hash_step = cext + (h << SH_LO) + (h << SH_HI) - h;
			end
		end
	endfunction

endpackage
`default_nettype wire

/* rtl/lhff_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lhff_if: valid/ready channels of the lexicon hash frequency filter
// One interface for the character stream and one for the pair results.
// ----------------------------------------------------------------------------
interface lhff_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [7:0]  char_code;
	logic        word_end;
	logic [30:0] entry_freq;

	modport source(output valid, output mode, output char_code, output word_end,
		output entry_freq, input ready);
	modport sink(input valid, input mode, input char_code, input word_end,
		input entry_freq, output ready);
endinterface

interface lhff_out_if;
	logic        valid;
	logic        ready;
	logic        keep_pair;
	logic [30:0] correct_freq;
	logic [30:0] error_freq;

	modport source(output valid, output keep_pair, output correct_freq,
		output error_freq, input ready);
	modport sink(input valid, input keep_pair, input correct_freq,
		input error_freq, output ready);
endinterface
`default_nettype wire

/* rtl/lexicon_hash_freq_filter.sv */
`default_nettype none
// Path: after the last character of the error word is accepted, a lookup
//   passes through the register of every table cell and then the result
//   register, and is held there while the result side stalls.
// Throughput: one character per cycle unless the result side stalls; the cell chain is fully pipelined.
// Reset: arst_n clears the hashes, fill count, load-closed flag, ratio (to 5)
//   and all valid flags at once; table cells keep no reset, no clearing pass.
// ----------------------------------------------------------------------------
// lexicon_hash_freq_filter: sdbm hashed lexicon with frequency pair check
// Hashes character streams, loads lexicon entries into a chain of cells and
// looks up correct/error word pairs as they flow through the chain.
// ----------------------------------------------------------------------------
module lexicon_hash_freq_filter
	import lhff_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 256
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [7:0]   cfg_wdata,
	lhff_in_if.sink           word_in,
	lhff_out_if.source        pair_out
);

	localparam int unsigned IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CNTW = $clog2(TABLE_DEPTH + 1);

	logic [RATIO_W-1:0] ratio_q;
	logic [HASH_W-1:0]  run_q;
	logic [HASH_W-1:0]  held_q;
	logic [CNTW-1:0]    count_q;
	logic               closed_q;

	logic               adv;
	logic               acc;
	mode_t              mode;
	logic [HASH_W-1:0]  h_next;
	logic               word_done;
	logic               load_word;
	logic               load_we;

	tok_t               tok_chain  [TABLE_DEPTH+1];
	logic [CNTW-1:0]    snap_chain [TABLE_DEPTH+1];

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= RATIO_RESET;
		end else if (cfg_we) begin
			ratio_q <= cfg_wdata;
		end
	end

	// input transaction decode
	assign word_in.ready = adv;
	assign mode      = mode_t'(word_in.mode);
	assign acc       = word_in.valid && word_in.ready && (mode != MODE_NONE);
	assign h_next    = hash_step(run_q, word_in.char_code);
	assign word_done = acc && word_in.word_end;
	assign load_word = word_done && (mode == MODE_LEX) && !closed_q;
	assign load_we   = load_word && (count_q < CNTW'(TABLE_DEPTH));

	// running hash, held correct hash, fill count and load close
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= '0;
			held_q   <= '0;
			count_q  <= '0;
			closed_q <= 1'b0;
		end else if (acc) begin
			run_q <= word_in.word_end ? '0 : h_next;
			if (word_done && (mode == MODE_CORRECT)) begin
				held_q <= h_next;
			end
			if (load_we) begin
				count_q <= count_q + 1'b1;
			end
			if (load_word && (word_in.entry_freq <= FREQ_CLOSE)) begin
				closed_q <= 1'b1;
			end
		end
	end

	// lookup transaction entering the chain
	always_comb begin
		tok_chain[0].valid = word_done && (mode == MODE_ERROR);
		tok_chain[0].chash = held_q;
		tok_chain[0].ehash = h_next;
		tok_chain[0].cfreq = '0;
		tok_chain[0].efreq = '0;
	end
	assign snap_chain[0] = count_q;

	// row of table cells
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		lhff_cell #(
			.IDXW(IDXW),
			.CNTW(CNTW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.idx      (IDXW'(i)),
			.load_we  (load_we),
			.load_cnt (count_q),
			.load_hash(h_next),
			.load_freq(word_in.entry_freq),
			.tok_in   (tok_chain[i]),
			.snap_in  (snap_chain[i]),
			.tok_out  (tok_chain[i+1]),
			.snap_out (snap_chain[i+1])
		);
	end

	// ratio check and result register
	lhff_judge u_judge (
		.clk     (clk),
		.arst_n  (arst_n),
		.ratio   (ratio_q),
		.tok_in  (tok_chain[TABLE_DEPTH]),
		.adv     (adv),
		.pair_out(pair_out)
	);

`ifndef ASSERT_OFF
	// fill count never passes the table size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

	// once loading has closed no further entry is stored
	a_closed_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		closed_q |=> closed_q && $stable(count_q))
		else $error("table written after load closed");

	// a new result only comes from a lookup leaving the last cell
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pair_out.valid) |-> $past(tok_chain[TABLE_DEPTH].valid))
		else $error("result without a lookup transaction");
`endif

endmodule
`default_nettype wire

/* rtl/lhff_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lhff_cell: one table entry of the lexicon and one chain stage
// Stores a hash and frequency written once, and matches the passing lookup
// transaction against them; a later cell overrides an earlier match.
// ----------------------------------------------------------------------------
module lhff_cell
	import lhff_pkg::*;
#(
	parameter int unsigned IDXW = 8,
	parameter int unsigned CNTW = 9
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic [IDXW-1:0]   idx,
	input  wire logic              load_we,
	input  wire logic [CNTW-1:0]   load_cnt,
	input  wire logic [HASH_W-1:0] load_hash,
	input  wire logic [FREQ_W-1:0] load_freq,
	input  wire tok_t              tok_in,
	input  wire logic [CNTW-1:0]   snap_in,
	output tok_t                   tok_out,
	output logic [CNTW-1:0]        snap_out
);

	logic [HASH_W-1:0] hash_q;
	logic [FREQ_W-1:0] freq_q;
	logic              filled;
	logic              hit_c;
	logic              hit_e;
	tok_t              tok_d;
	tok_t              tok_q;
	logic              valid_q;
	logic [CNTW-1:0]   snap_q;

	// entry storage, written when the fill count points here
	always_ff @(posedge clk) begin
		if (load_we && (load_cnt == CNTW'(idx))) begin
			hash_q <= load_hash;
			freq_q <= load_freq;
		end
	end

	// only entries filled before the lookup started take part
	assign filled = (CNTW'(idx) < snap_in);
	assign hit_c  = filled && (hash_q == tok_in.chash);
	assign hit_e  = filled && (hash_q == tok_in.ehash);

	always_comb begin
		tok_d = tok_in;
		if (hit_c) begin
			tok_d.cfreq = freq_q;
		end
		if (hit_e) begin
			tok_d.efreq = freq_q;
		end
	end

	// chain stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= tok_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_q  <= tok_d;
			snap_q <= snap_in;
		end
	end

	// valid flag comes from the reset register
	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = valid_q;
	end
	assign snap_out = snap_q;

endmodule
`default_nettype wire

/* rtl/lhff_judge.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lhff_judge: ratio check and result register
// Scales the error frequency by the ratio, decides keep or reject and holds
// the pair result until it is taken.
// ----------------------------------------------------------------------------
module lhff_judge
	import lhff_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [RATIO_W-1:0] ratio,
	input  wire tok_t               tok_in,
	output logic                    adv,
	lhff_out_if.source              pair_out
);

	logic [PROD_W-1:0] prod;
	logic              reject;
	logic              valid_q;
	logic              keep_q;
	logic [FREQ_W-1:0] cfreq_q;
	logic [FREQ_W-1:0] efreq_q;

	// the chain moves whenever the result register is free or being emptied
	assign adv = !valid_q || pair_out.ready;

	// reject when the error word is too frequent against a known correct word
	assign prod   = PROD_W'(tok_in.efreq) * PROD_W'(ratio);
	assign reject = (prod > PROD_W'(tok_in.cfreq)) && (tok_in.cfreq != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			keep_q  <= !reject;
			cfreq_q <= tok_in.cfreq;
			efreq_q <= tok_in.efreq;
		end
	end

	assign pair_out.valid        = valid_q;
	assign pair_out.keep_pair    = keep_q;
	assign pair_out.correct_freq = cfreq_q;
	assign pair_out.error_freq   = efreq_q;

endmodule
`default_nettype wire
